FILE: hw/rtl/dblm_pkg.sv
// Package for the device baseline learn/monitor block.
// Holds function codes, alert codes, config indices, controller states,
// scan table selects and the command/status structs. No dependencies.
package dblm_pkg;

	localparam logic [2:0] FN_TICK     = 3'd0;
	localparam logic [2:0] FN_WIFI     = 3'd1;
	localparam logic [2:0] FN_BLE      = 3'd2;
	localparam logic [2:0] FN_RELEARN  = 3'd3;
	localparam logic [2:0] FN_ADD_WIFI = 3'd4;
	localparam logic [2:0] FN_ADD_BLE  = 3'd5;

	localparam logic [1:0] ALERT_NONE = 2'd0;
	localparam logic [1:0] ALERT_WIFI = 2'd1;
	localparam logic [1:0] ALERT_BLE  = 2'd2;

	localparam logic CFG_LEARN_WINDOW = 1'b0;
	localparam logic CFG_BLE_INTERVAL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_BASE,
		ST_SEEN,
		ST_WCACHE,
		ST_BCACHE,
		ST_FINISH
	} state_t;

	// which table the scan engine walks; base means the item's own radio
	typedef enum logic [1:0] {
		SEL_BASE,
		SEL_WCACHE,
		SEL_BCACHE
	} sel_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		sel_t scan_sel;
		logic base_wr;
		logic wc_ins;
		logic bc_ins;
		logic set_alert;
		logic set_added;
		logic do_lock;
		logic do_relearn;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       monitor;
		logic       scan_done;
		logic       scan_hit;
		logic       base_full;
		logic       lock_ok;
		logic       rate_ok;
		logic       out_busy;
	} sts_t;

endpackage

FILE: hw/rtl/dblm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dblm_ram #(
	parameter int W = 48,
	parameter int D = 64
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                    wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                    rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/dblm_ctrl.sv
// Controller FSM for the baseline learn/monitor block.
// Depends on dblm_pkg; drives dblm_dpath through cmd_t, reads sts_t.
module dblm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dblm_pkg::sts_t  sts,
	output dblm_pkg::cmd_t  cmd
);
	dblm_pkg::state_t state_q, state_d;

	logic sighting, adding;
	assign sighting = (sts.func == dblm_pkg::FN_WIFI) || (sts.func == dblm_pkg::FN_BLE);
	assign adding   = (sts.func == dblm_pkg::FN_ADD_WIFI) || (sts.func == dblm_pkg::FN_ADD_BLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dblm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dblm_pkg::ST_IDLE: begin
				if (in_valid) state_d = dblm_pkg::ST_DISPATCH;
			end
			dblm_pkg::ST_DISPATCH: begin
				if ((sighting && !(!sts.monitor && sts.base_full)) || (adding && !sts.base_full))
					state_d = dblm_pkg::ST_BASE;
				else
					state_d = dblm_pkg::ST_FINISH;
			end
			dblm_pkg::ST_BASE: begin
				if (sts.scan_done) begin
					if (sts.scan_hit || (sighting && !sts.monitor))
						state_d = dblm_pkg::ST_FINISH;
					else if (sighting)
						state_d = dblm_pkg::ST_SEEN;
					else
						state_d = dblm_pkg::ST_WCACHE;
				end
			end
			dblm_pkg::ST_SEEN: begin
				if (sts.scan_done) state_d = dblm_pkg::ST_FINISH;
			end
			dblm_pkg::ST_WCACHE: begin
				if (sts.scan_done) state_d = dblm_pkg::ST_BCACHE;
			end
			dblm_pkg::ST_BCACHE: begin
				if (sts.scan_done) state_d = dblm_pkg::ST_FINISH;
			end
			dblm_pkg::ST_FINISH: begin
				if (!sts.out_busy) state_d = dblm_pkg::ST_IDLE;
			end
			default: state_d = dblm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.scan_sel = dblm_pkg::SEL_BASE;
		in_ready = 1'b0;
		unique case (state_q)
			dblm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			dblm_pkg::ST_DISPATCH: begin
				if (sts.func == dblm_pkg::FN_TICK)
					cmd.do_lock = sts.lock_ok;
				if (sts.func == dblm_pkg::FN_RELEARN)
					cmd.do_relearn = 1'b1;
				if ((sighting && !(!sts.monitor && sts.base_full)) || (adding && !sts.base_full))
					cmd.scan_start = 1'b1;
			end
			dblm_pkg::ST_BASE: begin
				if (sts.scan_done && !sts.scan_hit) begin
					if (sighting && !sts.monitor) begin
						cmd.base_wr = 1'b1;
					end else if (sighting) begin
						cmd.scan_start = 1'b1;
						cmd.scan_sel = (sts.func == dblm_pkg::FN_BLE) ?
							dblm_pkg::SEL_BCACHE : dblm_pkg::SEL_WCACHE;
					end else begin
						cmd.base_wr = 1'b1;
						cmd.set_added = 1'b1;
						cmd.scan_start = 1'b1;
						cmd.scan_sel = dblm_pkg::SEL_WCACHE;
					end
				end
			end
			dblm_pkg::ST_SEEN: begin
				if (sts.scan_done && !sts.scan_hit) begin
					if (sts.func == dblm_pkg::FN_BLE) begin
						cmd.bc_ins = 1'b1;
						cmd.set_alert = sts.rate_ok;
					end else begin
						cmd.wc_ins = 1'b1;
						cmd.set_alert = 1'b1;
					end
				end
			end
			dblm_pkg::ST_WCACHE: begin
				if (sts.scan_done) begin
					cmd.wc_ins = !sts.scan_hit;
					cmd.scan_start = 1'b1;
					cmd.scan_sel = dblm_pkg::SEL_BCACHE;
				end
			end
			dblm_pkg::ST_BCACHE: begin
				if (sts.scan_done) cmd.bc_ins = !sts.scan_hit;
			end
			dblm_pkg::ST_FINISH: begin
				cmd.fin = !sts.out_busy;
			end
			default: ;
		endcase
	end
endmodule

FILE: hw/rtl/dblm_dpath.sv
// Datapath: item latch, config, mode/time state, baseline and seen-cache
// RAMs, the sequential scan engine and the result register.
// Depends on dblm_pkg and dblm_ram.
module dblm_dpath #(
	parameter int WIFI_TABLE_DEPTH = 64,
	parameter int BLE_TABLE_DEPTH  = 64,
	parameter int SEEN_CACHE_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dblm_pkg::cmd_t      cmd,
	output dblm_pkg::sts_t      sts,
	input  logic [2:0]          func,
	input  logic [31:0]         now_ms,
	input  logic [47:0]         device_mac,
	input  logic [7:0]          wifi_channel,
	input  logic signed [15:0]  signal_rssi,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_wdata,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          alert_kind,
	output logic [47:0]         alert_mac,
	output logic [15:0]         alert_extra,
	output logic                locked_now,
	output logic                entry_added,
	output logic                monitoring,
	output logic [6:0]          wifi_entries,
	output logic [6:0]          ble_entries
);
	localparam int WAW = WIFI_TABLE_DEPTH > 1 ? $clog2(WIFI_TABLE_DEPTH) : 1;
	localparam int BAW = BLE_TABLE_DEPTH > 1 ? $clog2(BLE_TABLE_DEPTH) : 1;
	localparam int SAW = SEEN_CACHE_DEPTH > 1 ? $clog2(SEEN_CACHE_DEPTH) : 1;
	localparam int WCW = $clog2(WIFI_TABLE_DEPTH + 1);
	localparam int BCW = $clog2(BLE_TABLE_DEPTH + 1);
	localparam int SCW = $clog2(SEEN_CACHE_DEPTH + 1);
	localparam int MAXD0 = WIFI_TABLE_DEPTH > BLE_TABLE_DEPTH ? WIFI_TABLE_DEPTH : BLE_TABLE_DEPTH;
	localparam int MAXD = MAXD0 > SEEN_CACHE_DEPTH ? MAXD0 : SEEN_CACHE_DEPTH;
	localparam int IW = $clog2(MAXD + 1);

	// item latch
	logic [2:0]  func_q;
	logic [31:0] now_q;
	logic [47:0] mac_q;
	logic [7:0]  chan_q;
	logic [15:0] rssi_q;

	logic [31:0] win_q, ivl_q, learn_start_q, last_ble_q;
	logic        monitor_q;
	logic [WCW-1:0] wcnt_q;
	logic [BCW-1:0] bcnt_q;
	logic [SCW-1:0] wfill_q, bfill_q;
	logic [SAW-1:0] whead_q, bhead_q;

	logic           scanning_q, pend_q, hit_q;
	dblm_pkg::sel_t sel_q;
	logic [IW-1:0]  idx_q, n_q;

	logic [1:0]  akind_q;
	logic [15:0] aextra_q;
	logic        locked_q, added_q;

	logic        ov_q;
	logic [1:0]  o_kind_q;
	logic [47:0] o_mac_q;
	logic [15:0] o_extra_q;
	logic        o_locked_q, o_added_q, o_mon_q;
	logic [6:0]  o_wcnt_q, o_bcnt_q;

	logic is_ble, base_full, wc_full, bc_full, issue;
	logic [47:0] wb_rd, bb_rd, wc_rd, bc_rd, rd_mux;
	logic [31:0] wcnt32, bcnt32;

	assign is_ble    = (func_q == dblm_pkg::FN_BLE) || (func_q == dblm_pkg::FN_ADD_BLE);
	assign base_full = is_ble ? (bcnt_q == BCW'(BLE_TABLE_DEPTH)) :
	                            (wcnt_q == WCW'(WIFI_TABLE_DEPTH));
	assign wc_full   = (wfill_q == SCW'(SEEN_CACHE_DEPTH));
	assign bc_full   = (bfill_q == SCW'(SEEN_CACHE_DEPTH));
	assign issue     = scanning_q && (idx_q < n_q);
	assign wcnt32    = 32'(wcnt_q);
	assign bcnt32    = 32'(bcnt_q);

	assign sts.func      = func_q;
	assign sts.monitor   = monitor_q;
	assign sts.scan_done = scanning_q && !issue && !pend_q;
	assign sts.scan_hit  = hit_q;
	assign sts.base_full = base_full;
	assign sts.lock_ok   = !monitor_q && ((now_q - learn_start_q) >= win_q);
	assign sts.rate_ok   = (now_q - last_ble_q) >= ivl_q;
	assign sts.out_busy  = ov_q && !out_ready;

	dblm_ram #(.W(48), .D(WIFI_TABLE_DEPTH)) u_wbase (
		.clk(clk), .we(cmd.base_wr && !is_ble), .waddr(wcnt_q[WAW-1:0]), .wdata(mac_q),
		.raddr(idx_q[WAW-1:0]), .rdata(wb_rd)
	);
	dblm_ram #(.W(48), .D(BLE_TABLE_DEPTH)) u_bbase (
		.clk(clk), .we(cmd.base_wr && is_ble), .waddr(bcnt_q[BAW-1:0]), .wdata(mac_q),
		.raddr(idx_q[BAW-1:0]), .rdata(bb_rd)
	);
	dblm_ram #(.W(48), .D(SEEN_CACHE_DEPTH)) u_wcache (
		.clk(clk), .we(cmd.wc_ins), .waddr(wc_full ? whead_q : wfill_q[SAW-1:0]),
		.wdata(mac_q), .raddr(idx_q[SAW-1:0]), .rdata(wc_rd)
	);
	dblm_ram #(.W(48), .D(SEEN_CACHE_DEPTH)) u_bcache (
		.clk(clk), .we(cmd.bc_ins), .waddr(bc_full ? bhead_q : bfill_q[SAW-1:0]),
		.wdata(mac_q), .raddr(idx_q[SAW-1:0]), .rdata(bc_rd)
	);

	always_comb begin
		unique case (sel_q)
			dblm_pkg::SEL_BASE:   rd_mux = is_ble ? bb_rd : wb_rd;
			dblm_pkg::SEL_WCACHE: rd_mux = wc_rd;
			dblm_pkg::SEL_BCACHE: rd_mux = bc_rd;
			default:              rd_mux = wb_rd;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			now_q  <= now_ms;
			mac_q  <= device_mac;
			chan_q <= wifi_channel;
			rssi_q <= signal_rssi;
		end
		if (cmd.fin) begin
			o_kind_q   <= akind_q;
			o_mac_q    <= (akind_q == dblm_pkg::ALERT_NONE) ? 48'd0 : mac_q;
			o_extra_q  <= aextra_q;
			o_locked_q <= locked_q;
			o_added_q  <= added_q;
			o_mon_q    <= monitor_q;
			o_wcnt_q   <= wcnt32[6:0];
			o_bcnt_q   <= bcnt32[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 32'd300000;
			ivl_q <= 32'd3000;
			learn_start_q <= '0;
			last_ble_q <= '0;
			monitor_q <= 1'b0;
			wcnt_q <= '0;
			bcnt_q <= '0;
			wfill_q <= '0;
			bfill_q <= '0;
			whead_q <= '0;
			bhead_q <= '0;
			scanning_q <= 1'b0;
			pend_q <= 1'b0;
			hit_q <= 1'b0;
			sel_q <= dblm_pkg::SEL_BASE;
			idx_q <= '0;
			n_q <= '0;
			akind_q <= dblm_pkg::ALERT_NONE;
			aextra_q <= '0;
			locked_q <= 1'b0;
			added_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == dblm_pkg::CFG_LEARN_WINDOW) win_q <= cfg_wdata;
				else ivl_q <= cfg_wdata;
			end

			// scan engine: read address issued, then compared against the item in the next cycle
			pend_q <= issue;
			if (issue) idx_q <= idx_q + 1'b1;
			if (pend_q && (rd_mux == mac_q)) hit_q <= 1'b1;
			if (sts.scan_done) scanning_q <= 1'b0;
			if (cmd.scan_start) begin
				scanning_q <= 1'b1;
				sel_q <= cmd.scan_sel;
				idx_q <= '0;
				hit_q <= 1'b0;
				unique case (cmd.scan_sel)
					dblm_pkg::SEL_BASE:   n_q <= is_ble ? IW'(bcnt_q) : IW'(wcnt_q);
					dblm_pkg::SEL_WCACHE: n_q <= IW'(wfill_q);
					dblm_pkg::SEL_BCACHE: n_q <= IW'(bfill_q);
					default:              n_q <= '0;
				endcase
			end

			if (cmd.base_wr) begin
				if (is_ble) bcnt_q <= bcnt_q + 1'b1;
				else wcnt_q <= wcnt_q + 1'b1;
			end
			// full cache: overwrite the oldest slot and advance the head
			if (cmd.wc_ins) begin
				if (!wc_full) wfill_q <= wfill_q + 1'b1;
				else whead_q <= (whead_q == SAW'(SEEN_CACHE_DEPTH - 1)) ? '0 : whead_q + 1'b1;
			end
			if (cmd.bc_ins) begin
				if (!bc_full) bfill_q <= bfill_q + 1'b1;
				else bhead_q <= (bhead_q == SAW'(SEEN_CACHE_DEPTH - 1)) ? '0 : bhead_q + 1'b1;
			end
			if (cmd.set_alert) begin
				akind_q  <= is_ble ? dblm_pkg::ALERT_BLE : dblm_pkg::ALERT_WIFI;
				aextra_q <= is_ble ? rssi_q : {8'd0, chan_q};
				if (is_ble) last_ble_q <= now_q;
			end
			if (cmd.set_added) added_q <= 1'b1;
			if (cmd.do_lock) begin
				monitor_q <= 1'b1;
				locked_q  <= 1'b1;
			end
			if (cmd.do_relearn) begin
				wcnt_q <= '0;
				bcnt_q <= '0;
				wfill_q <= '0;
				bfill_q <= '0;
				whead_q <= '0;
				bhead_q <= '0;
				learn_start_q <= now_q;
				monitor_q <= 1'b0;
			end

			if (ov_q && out_ready) ov_q <= 1'b0;
			if (cmd.fin) begin
				ov_q <= 1'b1;
				akind_q <= dblm_pkg::ALERT_NONE;
				aextra_q <= '0;
				locked_q <= 1'b0;
				added_q <= 1'b0;
			end
		end
	end

	assign out_valid   = ov_q;
	assign alert_kind  = o_kind_q;
	assign alert_mac   = o_mac_q;
	assign alert_extra = o_extra_q;
	assign locked_now  = o_locked_q;
	assign entry_added = o_added_q;
	assign monitoring  = o_mon_q;
	assign wifi_entries = o_wcnt_q;
	assign ble_entries  = o_bcnt_q;

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.base_wr |-> !base_full) else $error("baseline write while full");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> (!scanning_q || sts.scan_done)) else $error("scan restarted");
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(ov_q && !out_ready)) else $error("result overwritten");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wfill_q <= SCW'(SEEN_CACHE_DEPTH) && bfill_q <= SCW'(SEEN_CACHE_DEPTH))
		else $error("cache fill overflow");
endmodule

FILE: hw/rtl/device_baseline_learn_monitor_core.sv
// Device baseline learn/monitor: Wi-Fi and BLE MAC baselines with seen caches.
// Top level; depends on dblm_pkg, dblm_ctrl, dblm_dpath (and dblm_ram).
// One item at a time. An item passes accept, dispatch and finish, plus
// one scan per table it consults; a scan reads each entry through the
// registered RAM read port and compares it. The worst case is an add event,
// which scans its baseline and both seen caches; a monitor sighting scans at
// most its baseline and its own seen cache. Finish waits while the previous
// result is still held; the result sits in an output register, so the next
// item is taken while it waits.
module device_baseline_learn_monitor_core #(
	parameter int WIFI_TABLE_DEPTH = 64,
	parameter int BLE_TABLE_DEPTH  = 64,
	parameter int SEEN_CACHE_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic [31:0]        now_ms,
	input  logic [47:0]        device_mac,
	input  logic [7:0]         wifi_channel,
	input  logic signed [15:0] signal_rssi,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_wdata,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         alert_kind,
	output logic [47:0]        alert_mac,
	output logic [15:0]        alert_extra,
	output logic               locked_now,
	output logic               entry_added,
	output logic               monitoring,
	output logic [6:0]         wifi_entries,
	output logic [6:0]         ble_entries
);
	dblm_pkg::cmd_t cmd;
	dblm_pkg::sts_t sts;

	dblm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	dblm_dpath #(
		.WIFI_TABLE_DEPTH(WIFI_TABLE_DEPTH),
		.BLE_TABLE_DEPTH(BLE_TABLE_DEPTH),
		.SEEN_CACHE_DEPTH(SEEN_CACHE_DEPTH)
	) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(func), .now_ms(now_ms), .device_mac(device_mac),
		.wifi_channel(wifi_channel), .signal_rssi(signal_rssi),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_ready(out_ready),
		.alert_kind(alert_kind), .alert_mac(alert_mac), .alert_extra(alert_extra),
		.locked_now(locked_now), .entry_added(entry_added), .monitoring(monitoring),
		.wifi_entries(wifi_entries), .ble_entries(ble_entries)
	);
endmodule

FILE: verif/tb.sv
// Testbench for device_baseline_learn_monitor_core: directed and random items
// checked against an in-bench predictor of the learn/monitor tables.
// Depends on dblm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
	localparam int TBL_DEPTH   = 64;
	localparam int CACHE_DEPTH = 32;
	localparam longint CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [47:0] mac;
		logic [15:0] extra;
		logic        locked;
		logic        added;
		logic        mon;
		logic [6:0]  wcnt;
		logic [6:0]  bcnt;
	} alert_rec_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	logic [2:0] func = 0;
	logic [31:0] now_ms = 0;
	logic [47:0] device_mac = 0;
	logic [7:0] wifi_channel = 0;
	logic signed [15:0] signal_rssi = 0;
	logic cfg_we = 0, cfg_index = 0;
	logic [31:0] cfg_wdata = 0;
	logic out_valid, out_ready = 0;
	logic [1:0] alert_kind;
	logic [47:0] alert_mac;
	logic [15:0] alert_extra;
	logic locked_now, entry_added, monitoring;
	logic [6:0] wifi_entries, ble_entries;

	device_baseline_learn_monitor_core dut (.*);

	always #10 clk = ~clk;

	// predictor state
	logic [31:0] m_window, m_ble_gap;
	logic        m_mon;
	logic [31:0] m_learn_t0, m_last_ble;
	logic [47:0] m_wtab[TBL_DEPTH], m_btab[TBL_DEPTH];
	int          m_wcnt, m_bcnt;
	logic [47:0] m_wseen[$], m_bseen[$];

	alert_rec_t pending[$];
	int  errors = 0;
	bit  quiet = 0;
	longint cycles = 0;
	logic [31:0] clock_ms = 0;
	logic [47:0] mac_pool[16];

	function automatic bit tab_has(ref logic [47:0] t[TBL_DEPTH], input int n,
			input logic [47:0] mac);
		for (int i = 0; i < n; i++)
			if (t[i] == mac) return 1;
		return 0;
	endfunction

	function automatic bit seen_insert(ref logic [47:0] q[$], input logic [47:0] mac);
		foreach (q[i])
			if (q[i] == mac) return 1;
		if (q.size() >= CACHE_DEPTH) void'(q.pop_front());
		q.push_back(mac);
		return 0;
	endfunction

	function automatic bit tab_add(ref logic [47:0] t[TBL_DEPTH], ref int n,
			input logic [47:0] mac);
		if (n >= TBL_DEPTH || tab_has(t, n, mac)) return 0;
		t[n] = mac;
		n++;
		return 1;
	endfunction

	function automatic alert_rec_t predict_alert(logic [2:0] f, logic [31:0] t,
			logic [47:0] mac, logic [7:0] ch, logic [15:0] rs);
		alert_rec_t r;
		bit ok;
		r = '0;
		case (f)
			dblm_pkg::FN_TICK: if (!m_mon && (t - m_learn_t0) >= m_window) begin
				m_mon = 1;
				r.locked = 1;
			end
			dblm_pkg::FN_WIFI: if (!m_mon) void'(tab_add(m_wtab, m_wcnt, mac));
				else if (!tab_has(m_wtab, m_wcnt, mac) && !seen_insert(m_wseen, mac)) begin
					r.kind = dblm_pkg::ALERT_WIFI; r.mac = mac; r.extra = {8'd0, ch};
				end
			dblm_pkg::FN_BLE: if (!m_mon) void'(tab_add(m_btab, m_bcnt, mac));
				else if (!tab_has(m_btab, m_bcnt, mac) && !seen_insert(m_bseen, mac)) begin
					if ((t - m_last_ble) >= m_ble_gap) begin
						m_last_ble = t;
						r.kind = dblm_pkg::ALERT_BLE; r.mac = mac; r.extra = rs;
					end
				end
			dblm_pkg::FN_RELEARN: begin
				m_wcnt = 0; m_bcnt = 0;
				m_wseen.delete(); m_bseen.delete();
				m_learn_t0 = t;
				m_mon = 0;
			end
			dblm_pkg::FN_ADD_WIFI, dblm_pkg::FN_ADD_BLE: begin
				ok = (f == dblm_pkg::FN_ADD_WIFI) ? tab_add(m_wtab, m_wcnt, mac)
					: tab_add(m_btab, m_bcnt, mac);
				if (ok) begin
					r.added = 1;
					void'(seen_insert(m_wseen, mac));
					void'(seen_insert(m_bseen, mac));
				end
			end
			default: ;
		endcase
		r.mon = m_mon;
		r.wcnt = m_wcnt[6:0];
		r.bcnt = m_bcnt[6:0];
		return r;
	endfunction

	task automatic idle_gap();
		if (!quiet && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 16)) @(negedge clk);
	endtask

	task automatic send_item(logic [2:0] f, logic [31:0] t, logic [47:0] mac,
			logic [7:0] ch, logic [15:0] rs);
		idle_gap();
		@(negedge clk);
		in_valid <= 1;
		func <= f; now_ms <= t; device_mac <= mac;
		wifi_channel <= ch; signal_rssi <= rs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending.push_back(predict_alert(f, t, mac, ch, rs));
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic drain();
		while (pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == dblm_pkg::CFG_LEARN_WINDOW) m_window = val; else m_ble_gap = val;
	endtask

	// receiver stalls
	initial begin
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		alert_rec_t e;
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = pending.pop_front();
				if (alert_kind !== e.kind) begin
					$error("alert_kind exp %0d got %0d", e.kind, alert_kind); errors++; end
				if (alert_mac !== e.mac) begin
					$error("alert_mac exp %h got %h", e.mac, alert_mac); errors++; end
				if (alert_extra !== e.extra) begin
					$error("alert_extra exp %h got %h", e.extra, alert_extra); errors++; end
				if (locked_now !== e.locked) begin
					$error("locked_now exp %0d got %0d", e.locked, locked_now); errors++; end
				if (entry_added !== e.added) begin
					$error("entry_added exp %0d got %0d", e.added, entry_added); errors++; end
				if (monitoring !== e.mon) begin
					$error("monitoring exp %0d got %0d", e.mon, monitoring); errors++; end
				if (wifi_entries !== e.wcnt) begin
					$error("wifi_entries exp %0d got %0d", e.wcnt, wifi_entries); errors++; end
				if (ble_entries !== e.bcnt) begin
					$error("ble_entries exp %0d got %0d", e.bcnt, ble_entries); errors++; end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [47:0] rand_mac();
		return {16'($urandom_range(0, 65535)), 32'($urandom())};
	endfunction

	task automatic test_directed();
		logic [47:0] all1;
		all1 = '1;
		send_item(3'd6, 32'd5, all1, 8'hff, 16'hffff);
		send_item(3'd7, 32'd0, 48'd0, 8'd0, 16'd0);
		send_item(dblm_pkg::FN_TICK, 32'd100, 48'd0, 8'd0, 16'd0);   // too early to lock
		send_item(dblm_pkg::FN_WIFI, 32'd200, 48'd0, 8'd0, 16'd0);
		send_item(dblm_pkg::FN_WIFI, 32'd201, all1, 8'hff, 16'd0);
		send_item(dblm_pkg::FN_WIFI, 32'd202, all1, 8'h01, 16'd0);    // duplicate in learn
		send_item(dblm_pkg::FN_BLE, 32'd203, all1, 8'd0, 16'h8000);
		send_item(dblm_pkg::FN_ADD_WIFI, 32'd204, 48'h123456789abc, 8'd0, 16'd0);
		send_item(dblm_pkg::FN_ADD_WIFI, 32'd205, 48'h123456789abc, 8'd0, 16'd0); // present
		send_item(dblm_pkg::FN_TICK, 32'd300000, 48'd0, 8'd0, 16'd0); // locks
		send_item(dblm_pkg::FN_TICK, 32'd300001, 48'd0, 8'd0, 16'd0); // no effect in monitor
		send_item(dblm_pkg::FN_WIFI, 32'd300002, 48'h5555_aaaa_5555, 8'h80, 16'd0);
		send_item(dblm_pkg::FN_WIFI, 32'd300003, 48'h5555_aaaa_5555, 8'h80, 16'd0); // cached
		send_item(dblm_pkg::FN_BLE, 32'd300004, 48'haaaa_5555_aaaa, 8'd0, 16'h7fff);
		send_item(dblm_pkg::FN_BLE, 32'd300005, 48'h0f0f_0f0f_0f0f, 8'd0, 16'h0001); // rate dropped
		send_item(dblm_pkg::FN_BLE, 32'd310000, 48'h0f0f_0f0f_0f0f, 8'd0, 16'h0001); // still cached
		send_item(dblm_pkg::FN_ADD_BLE, 32'd310001, 48'h0f0f_0f0f_0f0f, 8'd0, 16'd0);
		send_item(dblm_pkg::FN_BLE, 32'hffff_ffff, 48'h1, 8'd0, 16'hffff);
		send_item(dblm_pkg::FN_RELEARN, 32'hffff_fff0, 48'd0, 8'd0, 16'd0);
		send_item(dblm_pkg::FN_TICK, 32'h0004_93e0, 48'd0, 8'd0, 16'd0); // wrapped difference
		drain();
	endtask

	// fill the Wi-Fi table and the Wi-Fi seen cache past capacity
	task automatic test_capacity();
		send_item(dblm_pkg::FN_RELEARN, clock_ms, 48'd0, 8'd0, 16'd0);
		for (int i = 0; i < 70; i++)
			send_item((i & 1) ? dblm_pkg::FN_WIFI : dblm_pkg::FN_BLE, clock_ms,
				{16'hc0de, 32'(i >> 1)}, 8'd0, 16'd0);
		for (int i = 0; i < 70; i++)
			send_item(dblm_pkg::FN_ADD_WIFI, clock_ms, {16'hbeef, 32'(i)}, 8'd0, 16'd0);
		send_item(dblm_pkg::FN_ADD_BLE, clock_ms, 48'h42, 8'd0, 16'd0);
		send_item(dblm_pkg::FN_TICK, clock_ms, 48'd0, 8'd0, 16'd0);
		for (int i = 0; i < 40; i++)
			send_item(dblm_pkg::FN_WIFI, clock_ms, {16'hfeed, 32'(i)}, 8'(i), 16'd0);
		// evicted, alerts again
		send_item(dblm_pkg::FN_WIFI, clock_ms, {16'hfeed, 32'd0}, 8'd1, 16'd0);
		drain();
	endtask

	task automatic test_random(int n);
		logic [2:0] f;
		logic [47:0] mac;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3) f = dblm_pkg::FN_RELEARN;
			else if (r < 12) f = dblm_pkg::FN_TICK;
			else if (r < 48) f = dblm_pkg::FN_WIFI;
			else if (r < 84) f = dblm_pkg::FN_BLE;
			else if (r < 91) f = dblm_pkg::FN_ADD_WIFI;
			else if (r < 98) f = dblm_pkg::FN_ADD_BLE;
			else f = 3'($urandom_range(6, 7));
			clock_ms += 32'($urandom_range(0, 4000));
			mac = ($urandom_range(0, 2) != 0) ? mac_pool[$urandom_range(0, 15)] : rand_mac();
			send_item(f, ($urandom_range(0, 30) == 0) ? 32'($urandom()) : clock_ms, mac,
				8'($urandom()), 16'($urandom()));
			if (i == n / 2) drain(); // let everything settle mid-run
		end
	endtask

	initial begin
		m_window = 32'd300000; m_ble_gap = 32'd3000;
		m_mon = 0; m_learn_t0 = 0; m_last_ble = 0;
		m_wcnt = 0; m_bcnt = 0;
		foreach (mac_pool[i]) mac_pool[i] = rand_mac();
		repeat (6) @(negedge clk);
		arst_n = 1;
		test_directed();
		write_reg(dblm_pkg::CFG_LEARN_WINDOW, 32'd0);
		write_reg(dblm_pkg::CFG_BLE_INTERVAL, 32'd0);
		test_capacity();
		write_reg(dblm_pkg::CFG_LEARN_WINDOW, 32'd20000);
		write_reg(dblm_pkg::CFG_BLE_INTERVAL, 32'd2500);
		test_random(300);
		drain();
		write_reg(dblm_pkg::CFG_LEARN_WINDOW, 32'hffff_ffff);
		write_reg(dblm_pkg::CFG_BLE_INTERVAL, 32'hffff_ffff);
		test_random(100);
		drain();
		write_reg(dblm_pkg::CFG_LEARN_WINDOW, 32'd5000);
		write_reg(dblm_pkg::CFG_BLE_INTERVAL, 32'd1000);
		quiet = 1;
		test_random(150);
		drain();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
